### sv/pfa_pkg.sv
// Package: sizes, codes and command/status types of the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

   // Managed map geometry
   localparam int NUM_PAGES  = 4096;
   localparam int PAGE_SHIFT = 12;
   localparam int WORD_W     = 64;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int NUM_WORDS  = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int WA_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int IDX_W      = WA_W + BIT_W;

   // Field widths
   localparam int ADDR_W  = 40;
   localparam int CNT_W   = 13;
   localparam int STS_W   = 2;
   localparam int OFF_W   = ADDR_W - PAGE_SHIFT;
   localparam int CSR_I_W = 2;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Response status codes
   localparam logic [STS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STS_W-1:0] ST_NONE = 2'd1;
   localparam logic [STS_W-1:0] ST_BAD  = 2'd2;

   // Register indexes
   localparam logic [CSR_I_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_I_W-1:0] CSR_PAGES = 2'd1;
   localparam logic [CSR_I_W-1:0] CSR_FIRST = 2'd2;

   typedef struct packed {
      logic alloc_prep;
      logic scan;
      logic make_addr;
      logic free_sub;
      logic free_read;
      logic free_write;
      logic res_none;
      logic res_bad;
   } pfa_cmd_type;

   typedef struct packed {
      logic req_kind;
      logic start_ok;
      logic found;
      logic last_word;
      logic free_bad;
   } pfa_sts_type;

endpackage
`default_nettype wire

### sv/pfa_req_if.sv
// Interface: request channel of the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
interface pfa_req_if
   import pfa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ADDR_W-1:0] free_address;

   modport source (output valid, output kind, output free_address, input ready);
   modport sink   (input valid, input kind, input free_address, output ready);
endinterface
`default_nettype wire

### sv/pfa_rsp_if.sv
// Interface: response channel of the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
interface pfa_rsp_if
   import pfa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] page_address;
   logic [STS_W-1:0]  status;

   modport source (output valid, output page_address, output status, input ready);
   modport sink   (input valid, input page_address, input status, output ready);
endinterface
`default_nettype wire

### sv/pfa_ctrl.sv
// Controller: sequences allocate scans and free read-modify-writes.
`timescale 1ns / 1ps
`default_nettype none
module pfa_ctrl
   import pfa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire pfa_sts_type sts,
   output pfa_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ASTART = 3'd1;
   localparam logic [2:0] S_ASCAN  = 3'd2;
   localparam logic [2:0] S_AADDR  = 3'd3;
   localparam logic [2:0] S_FSUB   = 3'd4;
   localparam logic [2:0] S_FCHK   = 3'd5;
   localparam logic [2:0] S_FWR    = 3'd6;
   localparam logic [2:0] S_RSP    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = (sts.req_kind == KIND_FREE) ? S_FSUB : S_ASTART;
            end
         end
         S_ASTART: begin
            if (sts.start_ok) begin
               cmd.alloc_prep = 1'b1;
               state_in       = S_ASCAN;
            end else begin
               cmd.res_none = 1'b1;
               state_in     = S_RSP;
            end
         end
         S_ASCAN: begin
            cmd.scan = 1'b1;
            if (sts.found) begin
               state_in = S_AADDR;
            end else if (sts.last_word) begin
               cmd.res_none = 1'b1;
               state_in     = S_RSP;
            end
         end
         S_AADDR: begin
            cmd.make_addr = 1'b1;
            state_in      = S_RSP;
         end
         S_FSUB: begin
            cmd.free_sub = 1'b1;
            state_in     = S_FCHK;
         end
         S_FCHK: begin
            if (sts.free_bad) begin
               cmd.res_bad = 1'b1;
               state_in    = S_RSP;
            end else begin
               cmd.free_read = 1'b1;
               state_in      = S_FWR;
            end
         end
         S_FWR: begin
            cmd.free_write = 1'b1;
            state_in       = S_RSP;
         end
         S_RSP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### sv/pfa_dpath.sv
// Datapath: config registers, allocation bitmap memory, scan and address logic.
`timescale 1ns / 1ps
`default_nettype none
module pfa_dpath
   import pfa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CSR_I_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]  csr_wdata,
   input  wire logic               req_take,
   input  wire logic               req_kind,
   input  wire logic [ADDR_W-1:0]  req_free_address,
   input  wire pfa_cmd_type        cmd,
   output pfa_sts_type             sts,
   output logic [ADDR_W-1:0]       rsp_page_address,
   output logic [STS_W-1:0]        rsp_status
);

   // Configuration
   logic [ADDR_W-1:0] base_ff;
   logic [CNT_W-1:0]  pages_ff;
   logic [CNT_W-1:0]  first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         pages_ff <= CNT_W'(4096);
         first_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE:  base_ff  <= csr_wdata;
            CSR_PAGES: pages_ff <= csr_wdata[CNT_W-1:0];
            CSR_FIRST: first_ff <= csr_wdata[CNT_W-1:0];
            default:   ;
         endcase
      end
   end

   logic [CNT_W-1:0] count;
   logic [CNT_W-1:0] count_m1;
   assign count    = (32'(pages_ff) > NUM_PAGES) ? CNT_W'(NUM_PAGES) : pages_ff;
   assign count_m1 = count - CNT_W'(1);

   // Bitmap memory, one row per 64 pages; a row never written reads as all free
   logic [WORD_W-1:0] map_mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] row_vld_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic [WORD_W-1:0] rd_word;
   logic [WA_W-1:0]   rd_addr;
   logic              wr_en;
   logic [WA_W-1:0]   wr_addr;
   logic [WORD_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= row_vld_ff[rd_addr];
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_word = rd_vld_ff ? rd_data_ff : '0;

   // Scan bookkeeping
   logic [WA_W-1:0]  word_ff;
   logic [WA_W-1:0]  start_word_ff;
   logic [BIT_W-1:0] start_bit_ff;
   logic [WA_W-1:0]  end_word_ff;
   logic [BIT_W-1:0] end_bit_ff;
   logic [IDX_W-1:0] idx_ff;

   // Free bookkeeping
   logic [ADDR_W-1:0] addr_ff;
   logic [OFF_W-1:0]  off_ff;
   logic              below_ff;
   logic              zero_ff;
   logic [ADDR_W:0]   diff;
   logic [WA_W-1:0]   free_word;
   logic [BIT_W-1:0]  free_bit;

   assign diff      = {1'b0, addr_ff} - {1'b0, base_ff};
   assign free_word = idx_ff[IDX_W-1:BIT_W];
   assign free_bit  = idx_ff[BIT_W-1:0];

   // Candidate free bits of the current word within [start, count)
   logic [WORD_W-1:0] lo_mask;
   logic [WORD_W-1:0] hi_mask;
   logic [WORD_W-1:0] cand;
   logic [BIT_W-1:0]  pos;
   logic              found;

   assign lo_mask = (word_ff == start_word_ff) ? ({WORD_W{1'b1}} << start_bit_ff)
                                               : {WORD_W{1'b1}};
   assign hi_mask = (word_ff == end_word_ff)
                    ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - end_bit_ff))
                    : {WORD_W{1'b1}};
   assign cand    = ~rd_word & lo_mask & hi_mask;
   assign found   = |cand;

   always_comb begin
      pos = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (cand[b]) begin
            pos = BIT_W'(b);
         end
      end
   end

   always_comb begin
      rd_addr = word_ff + WA_W'(1);
      wr_en   = 1'b0;
      wr_addr = word_ff;
      wr_data = rd_word | (WORD_W'(1) << pos);
      if (cmd.alloc_prep) begin
         rd_addr = WA_W'(first_ff >> BIT_W);
      end else if (cmd.free_read) begin
         rd_addr = free_word;
      end
      if (cmd.scan && found) begin
         wr_en = 1'b1;
      end else if (cmd.free_write) begin
         wr_en   = 1'b1;
         wr_addr = free_word;
         wr_data = rd_word & ~(WORD_W'(1) << free_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         addr_ff <= req_free_address;
      end
      if (cmd.alloc_prep) begin
         word_ff       <= WA_W'(first_ff >> BIT_W);
         start_word_ff <= WA_W'(first_ff >> BIT_W);
         start_bit_ff  <= first_ff[BIT_W-1:0];
         end_word_ff   <= WA_W'(count_m1 >> BIT_W);
         end_bit_ff    <= count_m1[BIT_W-1:0];
      end else if (cmd.scan && !found) begin
         word_ff <= word_ff + WA_W'(1);
      end
      if (cmd.scan && found) begin
         idx_ff <= (IDX_W'(word_ff) << BIT_W) | IDX_W'(pos);
      end else if (cmd.free_sub) begin
         idx_ff <= IDX_W'(diff[ADDR_W-1:PAGE_SHIFT]);
      end
      if (cmd.free_sub) begin
         off_ff   <= diff[ADDR_W-1:PAGE_SHIFT];
         below_ff <= diff[ADDR_W];
         zero_ff  <= (addr_ff == '0);
      end
   end

   // Response payload
   logic [ADDR_W-1:0] page_address_ff;
   logic [STS_W-1:0]  status_ff;

   always_ff @(posedge clock) begin
      if (cmd.make_addr) begin
         page_address_ff <= base_ff + (ADDR_W'(idx_ff) << PAGE_SHIFT);
         status_ff       <= ST_DONE;
      end else if (cmd.res_none) begin
         page_address_ff <= '0;
         status_ff       <= ST_NONE;
      end else if (cmd.res_bad) begin
         page_address_ff <= '0;
         status_ff       <= ST_BAD;
      end else if (cmd.free_write) begin
         page_address_ff <= '0;
         status_ff       <= ST_DONE;
      end
   end

   assign rsp_page_address = page_address_ff;
   assign rsp_status       = status_ff;

   assign sts.req_kind  = req_kind;
   assign sts.start_ok  = (first_ff < count);
   assign sts.found     = found;
   assign sts.last_word = (word_ff == end_word_ff);
   assign sts.free_bad  = zero_ff || below_ff || (off_ff >= OFF_W'(count));

endmodule
`default_nettype wire

### sv/page_frame_allocator_top.sv
// Allocate: start check, scan of k map words (k = 1..64), address step, then response valid;
// no address step when no page is free, no scan when the scan start is not below the page count.
// Free: subtract, check, one map read-modify-write, then response valid; a bad free skips the write.
// One request in flight; the next transfer is taken the cycle after the response transfer.
// Reset is synchronous: control, base and first registers and 64 row-valid bits clear, page count
// resets to 4096, so the map reads all free at once with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_allocator_top
   import pfa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CSR_I_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]  csr_wdata,
   pfa_req_if.sink                 req_ch,
   pfa_rsp_if.source               rsp_ch
);

   pfa_cmd_type cmd;
   pfa_sts_type sts;
   logic        req_ready;

   assign req_ch.ready = req_ready;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pfa_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_take         (req_ch.valid && req_ready),
      .req_kind         (req_ch.kind),
      .req_free_address (req_ch.free_address),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_page_address (rsp_ch.page_address),
      .rsp_status       (rsp_ch.status)
   );

endmodule
`default_nettype wire
